// ===== src/smm_pkg.sv =====
// ============================================================================
// smm_pkg
// Shared types and constants for the sum / mean / median statistics block.
// ============================================================================
package smm_pkg;

    // Default sizing
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed-point scaling: mean and median are reported in hundredths,
    // computed from thousandths rounded half away from zero.
    localparam int MEAN_SCALE = 1000;
    localparam int DEN_SCALE  = 10;
    localparam int ROUND_HALF = 5;
    localparam int MED_SCALE  = MEAN_SCALE / (2 * DEN_SCALE);

    // Register map (index = paddr[2])
    localparam logic REG_ITEM_COUNT   = 1'b0;
    localparam int   ITEM_COUNT_RESET = 1;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUM,
        OP_SORT_INIT,
        OP_KEY_RD,
        OP_KEY_CAP,
        OP_CMP,
        OP_INS0,
        OP_MED_HI,
        OP_MED_LO,
        OP_MED_CAP,
        OP_MED_MUL
    } smm_op_t;

    typedef struct packed {
        smm_op_t op;
        logic    div_start;
        logic    emit;
    } smm_cmd_t;

    typedef struct packed {
        logic sum_last;
        logic sort_done;
        logic gt;
        logic b_zero;
        logic div_done;
    } smm_sts_t;

endpackage

// ===== src/smm_div.sv =====
// ============================================================================
// smm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module smm_div
    import smm_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;

    logic [DEN_W:0]   shifted;
    logic             fits;
    logic [DEN_W:0]   diff;

    // trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // quotient / remainder shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign quo  = quo_reg;
    assign done = (cnt_reg == '0);

endmodule

// ===== src/smm_datapath.sv =====
// ============================================================================
// smm_datapath
// Sample store, sum accumulator, insertion-sort compare/move, median scaling
// and mean divider; driven by smm_ctrl operations.
// ============================================================================
module smm_datapath
    import smm_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7,
    parameter int SUM_W       = 22,
    parameter int HUND_W      = 23
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  smm_cmd_t                      cmd,
    output smm_sts_t                      sts,
    input  logic [CNT_W-1:0]              item_count,
    input  logic [IDX_W-1:0]              slot_index,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic                          final_load,
    output logic                          result_valid,
    output logic signed [SUM_W-1:0]       total_sum,
    output logic signed [HUND_W-1:0]      mean_hundredths,
    output logic signed [HUND_W-1:0]      median_hundredths
);

    localparam int NUM_W = SUM_W + 10;
    localparam int DEN_W = CNT_W + 4;
    localparam logic signed [HUND_W-1:0] MED_K = HUND_W'(MED_SCALE);

    // sample store
    logic signed [SAMPLE_BITS-1:0] mem [MAX_ITEMS];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;

    logic [CNT_W-1:0]              n_reg;
    logic [CNT_W-1:0]              k_reg;
    logic [CNT_W-1:0]              a_reg;
    logic [IDX_W-1:0]              b_reg;
    logic                          rvld_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SAMPLE_BITS-1:0] key_reg;
    logic signed [SAMPLE_BITS-1:0] hi_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [HUND_W-1:0]      med_reg;

    logic                          result_valid_reg;
    logic signed [SUM_W-1:0]       total_sum_reg;
    logic signed [HUND_W-1:0]      mean_reg;
    logic signed [HUND_W-1:0]      median_reg;

    logic [CNT_W-1:0]              n_clamp;
    logic                          slot_ok;
    logic [IDX_W-1:0]              half_idx;
    logic [IDX_W-1:0]              lo_idx;
    logic [IDX_W-1:0]              rd_addr;
    logic                          we;
    logic [IDX_W-1:0]              wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;
    logic                          gt;
    logic                          b_zero;
    logic [SUM_W-1:0]              sum_mag;
    logic [NUM_W-1:0]              div_num;
    logic [DEN_W-1:0]              div_den;
    logic [NUM_W-1:0]              div_quo;
    logic                          div_done;
    logic [HUND_W-1:0]             quo_h;
    logic signed [HUND_W-1:0]      pair_sum;

    // count clamped to 1..MAX_ITEMS
    always_comb
    begin
        if (item_count == '0)
        begin
            n_clamp = CNT_W'(1);
        end
        else if (item_count > CNT_W'(MAX_ITEMS))
        begin
            n_clamp = CNT_W'(MAX_ITEMS);
        end
        else
        begin
            n_clamp = item_count;
        end
    end

    assign slot_ok  = ({1'b0, slot_index} < (IDX_W + 1)'(MAX_ITEMS));
    assign half_idx = IDX_W'(n_reg >> 1);
    assign lo_idx   = n_reg[0] ? half_idx : half_idx - 1'b1;
    assign gt       = (rdata_reg > key_reg);
    assign b_zero   = (b_reg == '0);

    // read address select
    always_comb
    begin
        unique case (cmd.op)
            OP_SUM:     rd_addr = k_reg[IDX_W-1:0];
            OP_KEY_RD:  rd_addr = a_reg[IDX_W-1:0];
            OP_KEY_CAP: rd_addr = b_reg;
            OP_CMP:     rd_addr = b_zero ? b_reg : b_reg - 1'b1;
            OP_MED_HI:  rd_addr = half_idx;
            OP_MED_LO:  rd_addr = lo_idx;
            default:    rd_addr = '0;
        endcase
    end

    // write port select: sample load, sort shift/insert
    always_comb
    begin
        we      = 1'b0;
        wr_addr = '0;
        wr_data = key_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                we      = slot_ok;
                wr_addr = slot_index;
                wr_data = sample_value;
            end
            OP_CMP:
            begin
                we      = 1'b1;
                wr_addr = b_reg + 1'b1;
                wr_data = gt ? rdata_reg : key_reg;
            end
            OP_INS0:
            begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = key_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // loop counters and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= CNT_W'(1);
            k_reg    <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            rvld_reg <= (cmd.op == OP_SUM);
            unique case (cmd.op)
                OP_LOAD:
                begin
                    k_reg <= '0;
                    if (final_load)
                    begin
                        n_reg <= n_clamp;
                    end
                end
                OP_SUM:       k_reg <= k_reg + 1'b1;
                OP_SORT_INIT: a_reg <= CNT_W'(1);
                OP_KEY_RD:    b_reg <= IDX_W'(a_reg - 1'b1);
                OP_CMP:
                begin
                    if (gt)
                    begin
                        if (!b_zero)
                        begin
                            b_reg <= b_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        a_reg <= a_reg + 1'b1;
                    end
                end
                OP_INS0:      a_reg <= a_reg + 1'b1;
                default:      ;
            endcase
        end
    end

    // sum, sort key and median operands
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            sum_reg <= '0;
        end
        else if (rvld_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(rdata_reg);
        end
        if (cmd.op == OP_KEY_CAP)
        begin
            key_reg <= rdata_reg;
        end
        if (cmd.op == OP_MED_LO)
        begin
            hi_reg <= rdata_reg;
        end
        if (cmd.op == OP_MED_CAP)
        begin
            lo_reg <= rdata_reg;
        end
        if (cmd.op == OP_MED_MUL)
        begin
            med_reg <= HUND_W'(pair_sum * MED_K);
        end
    end

    // median: (hi + lo) * 50, odd counts read the middle entry twice
    assign pair_sum = HUND_W'(hi_reg) + HUND_W'(lo_reg);

    // mean magnitude = (|sum|*1000 + 5n) / (10n), sign restored afterwards
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_num = NUM_W'(sum_mag) * NUM_W'(MEAN_SCALE)
                   + NUM_W'(n_reg) * NUM_W'(ROUND_HALF);
    assign div_den = DEN_W'(n_reg) * DEN_W'(DEN_SCALE);

    smm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign quo_h = div_quo[HUND_W-1:0];

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            total_sum_reg <= sum_reg;
            mean_reg      <= sum_reg[SUM_W-1] ? -$signed(quo_h) : $signed(quo_h);
            median_reg    <= med_reg;
        end
    end

    assign result_valid      = result_valid_reg;
    assign total_sum         = total_sum_reg;
    assign mean_hundredths   = mean_reg;
    assign median_hundredths = median_reg;

    // status to the controller
    assign sts.sum_last  = (k_reg == n_reg - 1'b1);
    assign sts.sort_done = (a_reg == n_reg);
    assign sts.gt        = gt;
    assign sts.b_zero    = b_zero;
    assign sts.div_done  = div_done;

endmodule

// ===== src/smm_ctrl.sv =====
// ============================================================================
// smm_ctrl
// Sequencer: load, sum sweep, insertion sort, median fetch, result beat.
// ============================================================================
module smm_ctrl
    import smm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     final_load,
    input  smm_sts_t sts,
    output smm_cmd_t cmd,
    output logic     busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_END,
        ST_DIV_GO,
        ST_KEY_RD,
        ST_KEY_WAIT,
        ST_CMP,
        ST_INS0,
        ST_MED_HI,
        ST_MED_LO,
        ST_MED_CAP,
        ST_MED_MUL,
        ST_WAIT_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and datapath command
    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (final_load)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.op = OP_SUM;
                if (sts.sum_last)
                begin
                    state_next = ST_SUM_END;
                end
            end
            ST_SUM_END:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.op        = OP_SORT_INIT;
                cmd.div_start = 1'b1;
                state_next    = ST_KEY_RD;
            end
            ST_KEY_RD:
            begin
                if (sts.sort_done)
                begin
                    state_next = ST_MED_HI;
                end
                else
                begin
                    cmd.op     = OP_KEY_RD;
                    state_next = ST_KEY_WAIT;
                end
            end
            ST_KEY_WAIT:
            begin
                cmd.op     = OP_KEY_CAP;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.op = OP_CMP;
                if (!sts.gt)
                begin
                    state_next = ST_KEY_RD;
                end
                else if (sts.b_zero)
                begin
                    state_next = ST_INS0;
                end
            end
            ST_INS0:
            begin
                cmd.op     = OP_INS0;
                state_next = ST_KEY_RD;
            end
            ST_MED_HI:
            begin
                cmd.op     = OP_MED_HI;
                state_next = ST_MED_LO;
            end
            ST_MED_LO:
            begin
                cmd.op     = OP_MED_LO;
                state_next = ST_MED_CAP;
            end
            ST_MED_CAP:
            begin
                cmd.op     = OP_MED_CAP;
                state_next = ST_MED_MUL;
            end
            ST_MED_MUL:
            begin
                cmd.op     = OP_MED_MUL;
                state_next = ST_WAIT_DIV;
            end
            ST_WAIT_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== src/sum_mean_median_stats.sv =====
// Loading: one sample beat per cycle; busy stays low while loading.
// After the final beat the sum sweep runs, then an in-place insertion sort over one
// store port and the median fetch; the result beat also waits for the mean divide,
// which runs alongside the sort.
// The result beat is a one-cycle strobe; the receiver cannot stall it.
// Reset (rst_n, async low) idles the sequencer and sets item_count to 1.
// ============================================================================
// sum_mean_median_stats
// Sample store with sum, mean and median (hundredths) over the first n slots.
// ============================================================================
module sum_mean_median_stats
    import smm_pkg::*;
#(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IDX_W       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    parameter int CNT_W       = $clog2(MAX_ITEMS + 1),
    parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_ITEMS),
    parameter int HUND_W      = SAMPLE_BITS + 7
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [IDX_W-1:0]              slot_index,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic                          final_load,
    // result channel
    output logic                          result_valid,
    output logic signed [SUM_W-1:0]       total_sum,
    output logic signed [HUND_W-1:0]      mean_hundredths,
    output logic signed [HUND_W-1:0]      median_hundredths,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [CNT_W-1:0] item_count_reg;
    logic             cfg_wr;
    smm_cmd_t         cmd;
    smm_sts_t         sts;

    // register write / readback
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= CNT_W'(ITEM_COUNT_RESET);
        end
        else if (cfg_wr && (paddr[2] == REG_ITEM_COUNT))
        begin
            item_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ITEM_COUNT) ? 32'(item_count_reg) : '0;

    smm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .final_load (final_load),
        .sts        (sts),
        .cmd        (cmd),
        .busy       (busy)
    );

    smm_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .HUND_W      (HUND_W)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .item_count        (item_count_reg),
        .slot_index        (slot_index),
        .sample_value      (sample_value),
        .final_load        (final_load),
        .result_valid      (result_valid),
        .total_sum         (total_sum),
        .mean_hundredths   (mean_hundredths),
        .median_hundredths (median_hundredths)
    );

`ifndef SYNTH
    // one result beat per final load, never back to back
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held two cycles");

    // result beat lands as the sequencer returns to idle
    a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result beat while busy");

    // a non-final beat keeps the block ready for the next beat
    a_load_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !final_load) |=> !busy)
        else $error("busy after non-final beat");

    // a final beat starts the computation
    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && final_load) |=> (busy && !result_valid))
        else $error("final beat did not start computation");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sum_mean_median_stats testbench
// Loads sample beats into the store and sets item_count over the APB port.
// Each final beat is checked against a local statistics predictor, or against a
// directed row's expected values: sum, mean and median in hundredths. A short
// directed table runs first, then phases of random data sets with varying sender idling.
// ============================================================================
module testbench;
    import smm_pkg::*;

    localparam int NSLOT         = MAX_ITEMS_DEF;
    localparam int IDX_W         = $clog2(NSLOT);
    localparam int SBITS         = SAMPLE_BITS_DEF;
    localparam int SUM_W         = SBITS + $clog2(NSLOT);
    localparam int HUND_W        = SBITS + 7;
    localparam int RANDOM_BEATS  = 450;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 2500;
    localparam logic [2:0] ITEM_COUNT_ADDR = {REG_ITEM_COUNT, 2'b00};

    typedef struct packed {
        logic signed [SUM_W-1:0]  total;
        logic signed [HUND_W-1:0] mean;
        logic signed [HUND_W-1:0] median;
    } stats_t;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [IDX_W-1:0]       slot;
        logic signed [SBITS-1:0] value;
        logic                   last;
        logic [6:0]             count;
        bit                     typed;
        stats_t                 stats;
    } row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [IDX_W-1:0]         slot_index;
    logic signed [SBITS-1:0]  sample_value;
    logic                     final_load;
    logic                     result_valid;
    logic signed [SUM_W-1:0]  total_sum;
    logic signed [HUND_W-1:0] mean_hundredths;
    logic signed [HUND_W-1:0] median_hundredths;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // Predictor state: store copy, count register, written slots
    logic signed [SBITS-1:0]  store_model [NSLOT];
    logic [6:0]               count_model;
    bit [NSLOT-1:0]           slot_written;
    stats_t                   pending_stats [$];
    stats_t                   got_stats;
    row_t                     directed_rows [$];
    int                       errors;
    int                       idle_pct;
    int                       beats_sent;

    sum_mean_median_stats DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .slot_index        (slot_index),
        .sample_value      (sample_value),
        .final_load        (final_load),
        .result_valid      (result_valid),
        .total_sum         (total_sum),
        .mean_hundredths   (mean_hundredths),
        .median_hundredths (median_hundredths),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run guard
    initial
    begin
        #50_000_000;
        $display("sum_mean_median_stats verification failed");
        $finish;
    end

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    // count register clamped to [1, NSLOT]
    function automatic int eff_count(input logic [6:0] raw);
        if (raw == 0)
            return 1;
        if (int'(raw) > NSLOT)
            return NSLOT;
        return int'(raw);
    endfunction

    // thousandths -> hundredths, half away from zero
    function automatic longint round_hundredths(input longint t);
        longint q;
        longint r;
        q = t / 10;
        r = t % 10;
        if (r >= 5)
            q++;
        else if (r <= -5)
            q--;
        return q;
    endfunction

    // Sum, mean and median over the first n slots; sorts them in place
    function automatic stats_t compute_stats();
        int                      n;
        int                      b;
        longint                  sum;
        longint                  avg;
        longint                  med;
        logic signed [SBITS-1:0] key;
        stats_t                  res;
        n   = eff_count(count_model);
        sum = 0;
        for (int k = 0; k < n; k++)
            sum += longint'(store_model[k]);
        res.total = sum[SUM_W-1:0];
        avg       = round_hundredths((sum * 1000) / n);
        res.mean  = avg[HUND_W-1:0];
        for (int a = 1; a < n; a++)
        begin
            key = store_model[a];
            b   = a - 1;
            while (b >= 0 && store_model[b] > key)
            begin
                store_model[b + 1] = store_model[b];
                b--;
            end
            store_model[b + 1] = key;
        end
        if ((n % 2) == 0)
            med = round_hundredths((longint'(store_model[n / 2]) +
                                    longint'(store_model[n / 2 - 1])) * 500);
        else
            med = round_hundredths(longint'(store_model[n / 2]) * 1000);
        res.median = med[HUND_W-1:0];
        return res;
    endfunction

    function automatic logic signed [SBITS-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 7))
            0: v = 32767;
            1: v = -32768;
            2, 3: v = int'($urandom_range(0, 8)) - 4;
            default: v = $urandom();
        endcase
        return v[SBITS-1:0];
    endfunction

    // One sample beat; held until accepted, then folded into the predictor
    task automatic drive_beat(input logic [IDX_W-1:0] slot,
                              input logic signed [SBITS-1:0] val,
                              input logic last, input bit typed, input stats_t exp_stats);
        stats_t s;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        slot_index   <= slot;
        sample_value <= val;
        final_load   <= last;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        store_model[slot]  = val;
        slot_written[slot] = 1'b1;
        if (last)
        begin
            s = compute_stats();
            pending_stats.push_back(typed ? exp_stats : s);
        end
    endtask

    // Quiet the sender until every result is in and the block has settled
    task automatic settle();
        start <= 1'b0;
        while (pending_stats.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of item_count, then read back
    task automatic write_count(input logic [6:0] v);
        logic [31:0] w;
        settle();
        w      = $urandom();
        w[6:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ITEM_COUNT_ADDR;
        pwdata  <= w;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        count_model = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {25'd0, v})
            report($sformatf("item_count read %0h, wrote %0h", prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_row(input row_kind_t kind, input int slot, input int val,
                           input int last, input int cnt, input int typed,
                           input stats_t s);
        row_t r;
        r.kind  = kind;
        r.slot  = slot[IDX_W-1:0];
        r.value = val[SBITS-1:0];
        r.last  = last[0];
        r.count = cnt[6:0];
        r.typed = typed[0];
        r.stats = s;
        directed_rows.push_back(r);
    endtask

    // Random phases: one count setting, then one to six data sets
    task automatic run_random();
        int             order [NSLOT];
        int             n;
        int             nsets;
        int             kind;
        int             k;
        int             tmp;
        int             target;
        logic [6:0]     cnt;
        bit [NSLOT-1:0] need;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target)
        begin
            if (target - beats_sent > 2 * RANDOM_BEATS / 3)
                idle_pct = 32;
            else if (target - beats_sent > RANDOM_BEATS / 3)
                idle_pct = 59;
            else
                idle_pct = 0;
            tmp = $urandom_range(0, 99);
            if (tmp < 8)
            begin
                case ($urandom_range(0, 4))
                    0: cnt = 7'd0;
                    1: cnt = 7'd1;
                    2: cnt = 7'd64;
                    3: cnt = 7'd65;
                    default: cnt = 7'd127;
                endcase
            end
            else if (tmp < 18)
                cnt = 7'($urandom_range(9, 40));
            else
                cnt = 7'($urandom_range(1, 8));
            write_count(cnt);
            n     = eff_count(cnt);
            nsets = (n > 16) ? 1 : $urandom_range(2, 6);
            need  = '0;
            for (int j = 0; j < n; j++)
                need[j] = 1'b1;
            for (int s = 0; s < nsets; s++)
            begin
                kind = $urandom_range(0, 99);
                if ((slot_written & need) != need || kind < 65)
                begin
                    // well-formed set: every counted slot once, shuffled, with occasional stray beats
                    for (int j = 0; j < n; j++)
                        order[j] = j;
                    for (int j = n - 1; j > 0; j--)
                    begin
                        k        = $urandom_range(0, j);
                        tmp      = order[j];
                        order[j] = order[k];
                        order[k] = tmp;
                    end
                    for (int j = 0; j < n; j++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            drive_beat(IDX_W'($urandom_range(0, NSLOT - 1)), rand_sample(),
                                       1'b0, 1'b0, '0);
                        drive_beat(IDX_W'(order[j]), rand_sample(), j == n - 1, 1'b0, '0);
                    end
                end
                else if (kind < 85)
                begin
                    // partial reload over a store already filled
                    k = $urandom_range(0, n);
                    for (int j = 0; j < k; j++)
                        drive_beat(IDX_W'($urandom_range(0, NSLOT - 1)), rand_sample(),
                                   1'b0, 1'b0, '0);
                    drive_beat(IDX_W'($urandom_range(0, NSLOT - 1)), rand_sample(),
                               1'b1, 1'b0, '0);
                end
                else
                begin
                    // loads with no final beat
                    k = $urandom_range(1, 6);
                    for (int j = 0; j < k; j++)
                        drive_beat(IDX_W'($urandom_range(0, NSLOT - 1)), rand_sample(),
                                   1'b0, 1'b0, '0);
                end
                if ($urandom_range(0, 9) == 0)
                    settle();
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_stats.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                got_stats = pending_stats.pop_front();
                if (total_sum !== got_stats.total)
                    report($sformatf("total_sum %0d, expected %0d",
                                     total_sum, got_stats.total));
                if (mean_hundredths !== got_stats.mean)
                    report($sformatf("mean_hundredths %0d, expected %0d",
                                     mean_hundredths, got_stats.mean));
                if (median_hundredths !== got_stats.median)
                    report($sformatf("median_hundredths %0d, expected %0d",
                                     median_hundredths, got_stats.median));
            end
        end
    end

    initial
    begin
        errors       = 0;
        beats_sent   = 0;
        idle_pct     = 32;
        count_model  = 7'(ITEM_COUNT_RESET);
        slot_written = '0;
        for (int i = 0; i < NSLOT; i++)
            store_model[i] = '0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        slot_index   <= '0;
        sample_value <= '0;
        final_load   <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;

        // Directed table: extremes after reset, count clamping, rounding
        add_row(ROW_BEAT, 0, 32767, 1, 0, 1,
                stats_t'{22'sd32767, 23'sd3276700, 23'sd3276700});
        add_row(ROW_BEAT, 0, -32768, 1, 0, 1,
                stats_t'{-22'sd32768, -23'sd3276800, -23'sd3276800});
        add_row(ROW_CFG, 0, 0, 0, 0, 0, '0);
        add_row(ROW_BEAT, 0, 7, 1, 0, 1, stats_t'{22'sd7, 23'sd700, 23'sd700});
        add_row(ROW_CFG, 0, 0, 0, 2, 0, '0);
        add_row(ROW_BEAT, 1, 32767, 0, 0, 0, '0);
        add_row(ROW_BEAT, 0, 32767, 1, 0, 1,
                stats_t'{22'sd65534, 23'sd3276700, 23'sd3276700});
        add_row(ROW_BEAT, 0, -32768, 0, 0, 0, '0);
        add_row(ROW_BEAT, 1, -32768, 1, 0, 1,
                stats_t'{-22'sd65536, -23'sd3276800, -23'sd3276800});
        add_row(ROW_BEAT, 1, -1, 0, 0, 0, '0);
        add_row(ROW_BEAT, 0, 0, 1, 0, 0, '0);
        add_row(ROW_CFG, 0, 0, 0, 3, 0, '0);
        add_row(ROW_BEAT, 0, 1, 0, 0, 0, '0);
        add_row(ROW_BEAT, 2, 0, 0, 0, 0, '0);
        add_row(ROW_BEAT, 1, 1, 1, 0, 0, '0);
        add_row(ROW_BEAT, 0, -1, 0, 0, 0, '0);
        add_row(ROW_BEAT, 1, -1, 0, 0, 0, '0);
        add_row(ROW_BEAT, 2, 0, 1, 0, 0, '0);
        add_row(ROW_CFG, 0, 0, 0, 8, 0, '0);
        add_row(ROW_BEAT, 3, 0, 0, 0, 0, '0);
        add_row(ROW_BEAT, 4, 0, 0, 0, 0, '0);
        add_row(ROW_BEAT, 5, 0, 0, 0, 0, '0);
        add_row(ROW_BEAT, 6, 0, 0, 0, 0, '0);
        add_row(ROW_BEAT, 7, -1, 1, 0, 0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_count(directed_rows[i].count);
            else
                drive_beat(directed_rows[i].slot, directed_rows[i].value,
                           directed_rows[i].last, directed_rows[i].typed,
                           directed_rows[i].stats);
        end

        run_random();

        // Drain and watch for stray results
        start <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("sum_mean_median_stats verification clean");
        else
            $display("sum_mean_median_stats verification failed");
        $finish;
    end

endmodule
